// ===== rtl/core/wsu_pkg.sv =====
// Package for the WebSocket frame unmasker: phase encoding, result kinds,
// header constants and the result record. No dependencies.
package wsu_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXT_HI = 3'd2,
    PH_EXT_LO = 3'd3,
    PH_MASK   = 3'd4,
    PH_DATA   = 3'd5
  } wsu_phase_t;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_CLOSE    = 3'd2,
    KIND_BIG      = 3'd3,
    KIND_UNMASKED = 3'd4
  } wsu_kind_t;

  localparam logic [3:0] OPC_CLOSE   = 4'h8;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [15:0] MASK_BYTES = 16'd4;

  // One result request
  typedef struct packed {
    wsu_kind_t  kind;
    logic [7:0] data_out;
    logic       last;
  } wsu_result_t;

endpackage

// ===== rtl/core/wsu_if.sv =====
// Channel interfaces: the input byte stream and the result stream.
// Depends on wsu_pkg.
interface wsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface wsu_result_if;
  logic               valid;
  logic               ready;
  wsu_pkg::wsu_kind_t kind;
  logic [7:0]         data_out;
  logic               last;

  modport source (output valid, output kind, output data_out, output last, input ready);
  modport sink   (input valid, input kind, input data_out, input last, output ready);
endinterface

// ===== rtl/core/wsu_parser.sv =====
// Header parser and unmask datapath: holds the frame state, decides the
// result for each accepted byte. Depends on wsu_pkg.
module wsu_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  output logic                res_vld,
  output wsu_pkg::wsu_result_t res
);
  import wsu_pkg::*;

  wsu_phase_t  phase_r, phase_nxt;
  logic        close_seen_r, close_seen_nxt;
  logic        mask_bit_r, mask_bit_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        halted_r, halted_nxt;

  logic [15:0] cnt_inc;
  logic [6:0]  code;
  logic [7:0]  mask_byte;

  assign cnt_inc = cnt_r + 16'd1;
  assign code    = in_byte[6:0];

  // Mask byte for the current payload index, first key byte in the top bits
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    mask_byte = key_r[31:24];
      2'd1:    mask_byte = key_r[23:16];
      2'd2:    mask_byte = key_r[15:8];
      default: mask_byte = key_r[7:0];
    endcase
  end

  // Next state for the byte at the input
  always_comb begin
    phase_nxt      = phase_r;
    close_seen_nxt = close_seen_r;
    mask_bit_nxt   = mask_bit_r;
    len_nxt        = len_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    halted_nxt     = halted_r;

    if (!halted_r) begin
      case (phase_r)
        PH_HDR1: begin
          mask_bit_nxt = in_byte[7];
          if (close_seen_r || (code == LEN_EXT64)) begin
            halted_nxt = 1'b1;
            phase_nxt  = PH_HDR0;
          end else if (code == LEN_EXT16) begin
            phase_nxt = PH_EXT_HI;
          end else if (!in_byte[7]) begin
            halted_nxt = 1'b1;
            phase_nxt  = PH_HDR0;
          end else begin
            len_nxt   = {9'd0, code};
            cnt_nxt   = 16'd0;
            key_nxt   = 32'd0;
            phase_nxt = PH_MASK;
          end
        end
        PH_EXT_HI: begin
          len_nxt   = {in_byte, 8'h00};
          phase_nxt = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          len_nxt = {len_r[15:8], in_byte};
          if (!mask_bit_r) begin
            halted_nxt = 1'b1;
            phase_nxt  = PH_HDR0;
          end else begin
            cnt_nxt   = 16'd0;
            key_nxt   = 32'd0;
            phase_nxt = PH_MASK;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_byte};
          if (cnt_inc < MASK_BYTES) begin
            cnt_nxt = cnt_inc;
          end else begin
            cnt_nxt = 16'd0;
            // zero-length frame ends right after its mask
            if (len_r == 16'd0) begin
              phase_nxt = PH_HDR0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (cnt_inc >= len_r) begin
            cnt_nxt   = 16'd0;
            phase_nxt = PH_HDR0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          // first header byte (also any undefined phase code)
          close_seen_nxt = (in_byte[3:0] == OPC_CLOSE);
          phase_nxt      = PH_HDR1;
        end
      endcase
    end
  end

  // Result for the byte at the input
  always_comb begin
    res_vld = 1'b0;
    res     = '{kind: KIND_DATA, data_out: 8'h00, last: 1'b0};

    if (!halted_r) begin
      case (phase_r)
        PH_HDR1: begin
          if (close_seen_r) begin
            res_vld  = 1'b1;
            res.kind = KIND_CLOSE;
          end else if (code == LEN_EXT64) begin
            res_vld  = 1'b1;
            res.kind = KIND_BIG;
          end else if ((code != LEN_EXT16) && !in_byte[7]) begin
            res_vld  = 1'b1;
            res.kind = KIND_UNMASKED;
          end
        end
        PH_EXT_LO: begin
          if (!mask_bit_r) begin
            res_vld  = 1'b1;
            res.kind = KIND_UNMASKED;
          end
        end
        PH_MASK: begin
          if ((cnt_inc >= MASK_BYTES) && (len_r == 16'd0)) begin
            res_vld  = 1'b1;
            res.kind = KIND_EMPTY;
            res.last = 1'b1;
          end
        end
        PH_DATA: begin
          res_vld      = 1'b1;
          res.kind     = KIND_DATA;
          res.data_out = in_byte ^ mask_byte;
          res.last     = (cnt_inc >= len_r);
        end
        default: begin
          res_vld = 1'b0;
        end
      endcase
    end
  end

  // State registers, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR0;
      close_seen_r <= 1'b0;
      mask_bit_r   <= 1'b0;
      len_r        <= 16'd0;
      key_r        <= 32'd0;
      cnt_r        <= 16'd0;
      halted_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      close_seen_r <= close_seen_nxt;
      mask_bit_r   <= mask_bit_nxt;
      len_r        <= len_nxt;
      key_r        <= key_nxt;
      cnt_r        <= cnt_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

// ===== rtl/core/wsu_out_reg.sv =====
// Result register between the parser and the output channel.
// Depends on wsu_pkg.
module wsu_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  wsu_pkg::wsu_result_t load_res,
  output logic                free,
  output logic                out_vld,
  input  logic                out_rdy,
  output wsu_pkg::wsu_result_t out_res
);
  import wsu_pkg::*;

  logic        vld_r, vld_nxt;
  wsu_result_t res_r;

  // Slot is free when empty or being drained this cycle
  assign free    = !vld_r || out_rdy;
  assign vld_nxt = load || (vld_r && !out_rdy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_vld = vld_r;
  assign out_res = res_r;

endmodule

// ===== rtl/core/websocket_frame_unmasker_top.sv =====
// Top level of the WebSocket frame unmasker: parser plus result register.
// Depends on wsu_pkg, wsu_if, wsu_parser and wsu_out_reg.
//
// Usage:
//   in_chan carries the client-to-server byte stream, one byte per request.
//   out_chan carries results: unmasked payload bytes (kind DATA, last on the
//   final byte), an EMPTY end for a zero-length frame, or one error (CLOSE,
//   BIG for length code 127, UNMASKED). Other header and mask bytes give no result.
//   Latency: a result is valid in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while out_chan does not stall; the parser state
//   and the one-entry result register both update once per accepted byte.
//   Stall: while a result waits and out_chan.ready is low, in_chan.ready is
//   low; it rises in the same cycle the waiting result is taken.
//   Reset (rst_n low, synchronous): parser expects a first header byte, the
//   result register is empty. After an error every byte is accepted and
//   dropped until the next reset.
module websocket_frame_unmasker_top (
  input  logic         clk,
  input  logic         rst_n,
  wsu_byte_if.sink     in_chan,
  wsu_result_if.source out_chan
);
  import wsu_pkg::*;

  logic        in_fire;
  logic        res_vld;
  logic        slot_free;
  wsu_result_t res;
  wsu_result_t out_res;

  assign in_chan.ready = slot_free;
  assign in_fire       = in_chan.valid && slot_free;

  wsu_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_chan.byte_in),
    .res_vld (res_vld),
    .res     (res)
  );

  wsu_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire && res_vld),
    .load_res (res),
    .free     (slot_free),
    .out_vld  (out_chan.valid),
    .out_rdy  (out_chan.ready),
    .out_res  (out_res)
  );

  assign out_chan.kind     = out_res.kind;
  assign out_chan.data_out = out_res.data_out;
  assign out_chan.last     = out_res.last;

endmodule

// ===== sim/websocket_frame_unmasker_top_tb.sv =====
// Testbench for websocket_frame_unmasker_top: streams masked client frames,
// predicts every unmasked byte, empty end and error, and checks the results.
// Depends on wsu_pkg, wsu_if and the RTL below websocket_frame_unmasker_top.
`timescale 1ns / 1ps

module websocket_frame_unmasker_top_tb;
  import wsu_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int STREAM_BYTES = 1650;
  localparam int NOISE_BYTES  = 30;

  // How the stream ends: each one stops the parser for the rest of the run
  typedef enum int {
    TAIL_CLOSE,
    TAIL_BIG,
    TAIL_UNMASKED,
    TAIL_UNMASKED_EXT
  } tail_t;

  logic clk;
  logic rst_n;

  wsu_byte_if   in_chan ();
  wsu_result_if out_chan ();

  websocket_frame_unmasker_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [7:0]  stream_bytes [$];
  wsu_result_t due_results [$];
  int          total_bytes = 0;
  int          accepted_bytes = 0;
  int          mismatches = 0;
  int          results_seen = 0;

  // Predicted parser state
  wsu_phase_t  p_phase = PH_HDR0;
  logic        p_close = 1'b0;
  logic        p_masked = 1'b0;
  logic [15:0] p_len = '0;
  logic [31:0] p_key = '0;
  logic [15:0] p_count = '0;
  logic        p_halted = 1'b0;

  // Clock and the single reset
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.byte_in = 8'h00;
    out_chan.ready = 1'b0;
    fork
      forever #6 clk = ~clk;
      begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_result(input wsu_kind_t k, input logic [7:0] d, input logic l);
    wsu_result_t r;
    r.kind = k;
    r.data_out = d;
    r.last = l;
    due_results.push_back(r);
  endfunction

  function automatic void halt_with(input wsu_kind_t k);
    p_halted = 1'b1;
    p_phase = PH_HDR0;
    push_result(k, 8'h00, 1'b0);
  endfunction

  function automatic void start_mask();
    p_count = '0;
    p_key = '0;
    p_phase = PH_MASK;
  endfunction

  // Advance the predicted parser by one accepted byte
  function automatic void parse_byte(input logic [7:0] b);
    int         sh;
    logic [7:0] mb;
    if (p_halted) return;
    case (p_phase)
      PH_HDR1: begin
        p_masked = b[7];
        if (p_close) halt_with(KIND_CLOSE);
        else if (b[6:0] == LEN_EXT64) halt_with(KIND_BIG);
        else if (b[6:0] == LEN_EXT16) p_phase = PH_EXT_HI;
        else if (!p_masked) halt_with(KIND_UNMASKED);
        else begin
          p_len = {9'd0, b[6:0]};
          start_mask();
        end
      end
      PH_EXT_HI: begin
        p_len = {b, 8'h00};
        p_phase = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        p_len[7:0] = b;
        if (!p_masked) halt_with(KIND_UNMASKED);
        else start_mask();
      end
      PH_MASK: begin
        p_key = {p_key[23:0], b};
        p_count = p_count + 16'd1;
        if (p_count == MASK_BYTES) begin
          p_count = '0;
          if (p_len == 16'd0) begin
            p_phase = PH_HDR0;
            push_result(KIND_EMPTY, 8'h00, 1'b1);
          end else begin
            p_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        // mask byte 0 sits in the top byte of the key
        sh = 24 - 8 * int'(p_count[1:0]);
        mb = p_key[sh +: 8];
        p_count = p_count + 16'd1;
        if (p_count >= p_len) begin
          p_count = '0;
          p_phase = PH_HDR0;
          push_result(KIND_DATA, b ^ mb, 1'b1);
        end else begin
          push_result(KIND_DATA, b ^ mb, 1'b0);
        end
      end
      default: begin
        p_close = (b[3:0] == OPC_CLOSE);
        p_phase = PH_HDR1;
      end
    endcase
  endfunction

  // First header byte with random FIN/RSV/opcode, never a close
  function automatic logic [7:0] rand_header0();
    logic [7:0] h0;
    h0 = 8'($urandom);
    if (h0[3:0] == OPC_CLOSE) h0[0] = 1'b1;
    return h0;
  endfunction

  // Queue one masked frame with random mask key and payload
  function automatic void add_frame(input int len, input bit ext);
    logic [15:0] l16;
    l16 = 16'(len);
    stream_bytes.push_back(rand_header0());
    if (ext) begin
      stream_bytes.push_back({1'b1, LEN_EXT16});
      stream_bytes.push_back(l16[15:8]);
      stream_bytes.push_back(l16[7:0]);
    end else begin
      stream_bytes.push_back({1'b1, l16[6:0]});
    end
    repeat (4) stream_bytes.push_back(8'($urandom));
    for (int i = 0; i < len; i++) stream_bytes.push_back(8'($urandom));
  endfunction

  // Build the byte stream and wait for the run to drain
  initial begin
    int    r;
    bit    wide_done;
    tail_t tail;
    wide_done = 1'b0;
    // zero-length frame, zero mask; two-byte frame with FIN clear and
    // all-ones / all-zeros mask bytes; 16-bit extended length of zero
    stream_bytes = {8'h81, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h02, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'hFF,
                    8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    while (stream_bytes.size() < STREAM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 12) add_frame(0, 1'b0);
      else if (r < 65) add_frame($urandom_range(1, 8), 1'b0);
      else if (r < 85) add_frame($urandom_range(9, 125), 1'b0);
      else if (r < 97 || wide_done) add_frame($urandom_range(0, 300), 1'b1);
      else begin
        add_frame(16'h0100 | $urandom_range(0, 255), 1'b1);
        wide_done = 1'b1;
      end
    end
    // the error that ends the run, then bytes that must be dropped
    tail = tail_t'($urandom_range(0, 3));
    case (tail)
      TAIL_CLOSE: begin
        stream_bytes.push_back({4'($urandom), OPC_CLOSE});
        stream_bytes.push_back(8'($urandom));
      end
      TAIL_BIG: begin
        stream_bytes.push_back(rand_header0());
        stream_bytes.push_back({1'($urandom), LEN_EXT64});
      end
      TAIL_UNMASKED: begin
        stream_bytes.push_back(rand_header0());
        stream_bytes.push_back({1'b0, 7'($urandom_range(0, 125))});
      end
      default: begin
        stream_bytes.push_back(rand_header0());
        stream_bytes.push_back({1'b0, LEN_EXT16});
        stream_bytes.push_back(8'($urandom));
        stream_bytes.push_back(8'($urandom));
      end
    endcase
    repeat (NOISE_BYTES) stream_bytes.push_back(8'($urandom));
    total_bytes = stream_bytes.size();

    @(posedge clk);
    while (accepted_bytes != total_bytes || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Byte driver: random gaps, with calm stretches that have none
  int tx_gap = 0;
  bit tx_calm = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        parse_byte(in_chan.byte_in);
        if ((accepted_bytes % 100) == 99) tx_calm = ($urandom_range(0, 2) == 0);
        accepted_bytes <= accepted_bytes + 1;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_chan.valid <= 1'b0;
        end else if (stream_bytes.size() != 0) begin
          in_chan.valid <= 1'b1;
          in_chan.byte_in <= stream_bytes.pop_front();
          tx_gap = tx_calm ? 0 : pick_gap();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off mid-run
  int rx_wait = 0;
  int rx_cycles = 0;
  int hold_left = 0;
  bit hold_armed = 1'b1;
  bit rx_calm = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if ((rx_cycles % 256) == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_armed && accepted_bytes >= 600) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
      end
    end
  end

  // Result checker: oldest prediction against each accepted result
  always @(posedge clk) begin
    wsu_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing predicted: kind %0d data %02h last %0b",
                                  results_seen, out_chan.kind, out_chan.data_out,
                                  out_chan.last));
      end else begin
        want = due_results.pop_front();
        if (out_chan.kind !== want.kind || out_chan.data_out !== want.data_out ||
            out_chan.last !== want.last)
          report_mismatch($sformatf("result %0d: kind %0d data %02h last %0b, want %0d %02h %0b",
                                    results_seen, out_chan.kind, out_chan.data_out,
                                    out_chan.last, want.kind, want.data_out, want.last));
      end
    end
  end

  // Watchdog on cycles with no request moved on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
